// File: sv/eicd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eicd_pkg
// shared types and constants of the edge id compaction and dedup unit
// ----------------------------------------------------------------------------
package eicd_pkg;

  localparam int RAW_W     = 16;
  localparam int DENSE_W   = 8;
  localparam int DENSE_IDS = 1 << DENSE_W;
  localparam int TOTAL_W   = 9;
  localparam int UNIQUE_W  = 17;
  localparam int MAP_W     = DENSE_W + 1;
  localparam int PAIR_W    = 2 * DENSE_W;
  localparam int RAW_DEPTH  = 1 << RAW_W;
  localparam int PAIR_DEPTH = 1 << PAIR_W;
  localparam int CLR_W     = (RAW_W > PAIR_W) ? RAW_W : PAIR_W;

  localparam logic [UNIQUE_W-1:0] UNIQUE_MAX = {UNIQUE_W{1'b1}};
  localparam logic [TOTAL_W-1:0]  DENSE_LIMIT = TOTAL_W'(DENSE_IDS);

  typedef struct packed {
    logic [RAW_W-1:0] left_raw_id;
    logic [RAW_W-1:0] right_raw_id;
  } in_item_t;

  typedef struct packed {
    logic [DENSE_W-1:0]  left_dense_id;
    logic [DENSE_W-1:0]  right_dense_id;
    logic                is_duplicate;
    logic                overflowed;
    logic [TOTAL_W-1:0]  left_total;
    logic [TOTAL_W-1:0]  right_total;
    logic [UNIQUE_W-1:0] unique_total;
  } out_item_t;

endpackage

// File: sv/eicd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eicd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module eicd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/edge_id_compaction_dedup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_id_compaction_dedup_unit
// relabels raw bipartite edge ids to dense first-seen ids and flags repeats
//
//   channel | ports                     | payload
//   input   | in_valid in_stall in_data | raw left id, raw right id
//   result  | out_valid out_stall out_data | dense ids, flags, running totals
//
// one item passes in turn through map read, map update with pair bitmap read,
// then bitmap update and result load; the two map rams and the pair ram set
// these steps; after reset a clearing pass zeroes all three rams, no item is
// taken during it
// a new item is taken while a finished result waits in the output register
// a stalled result holds the pair stage until the output register frees
// ----------------------------------------------------------------------------
module edge_id_compaction_dedup_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  eicd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output eicd_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_PAIR
  } state_t;

  state_t state_r, state_nxt;

  logic [eicd_pkg::CLR_W-1:0]    clr_r, clr_nxt;
  logic [eicd_pkg::RAW_W-1:0]    li_r, li_nxt;
  logic [eicd_pkg::RAW_W-1:0]    ri_r, ri_nxt;
  logic [eicd_pkg::DENSE_W-1:0]  ld_r, ld_nxt;
  logic [eicd_pkg::DENSE_W-1:0]  rd_r, rd_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [eicd_pkg::TOTAL_W-1:0]  lnext_r, lnext_nxt;
  logic [eicd_pkg::TOTAL_W-1:0]  rnext_r, rnext_nxt;
  logic [eicd_pkg::UNIQUE_W-1:0] uniq_r, uniq_nxt;
  logic                          out_valid_r, out_valid_nxt;
  eicd_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                         lmap_we, rmap_we, pair_we;
  logic [eicd_pkg::RAW_W-1:0]   lmap_waddr, rmap_waddr;
  logic [eicd_pkg::MAP_W-1:0]   lmap_wdata, rmap_wdata;
  logic [eicd_pkg::PAIR_W-1:0]  pair_waddr, pair_raddr;
  logic                         pair_wdata;
  logic                         map_re, pair_re;
  logic [eicd_pkg::MAP_W-1:0]   lmap_rdata, rmap_rdata;
  logic                         pair_rdata;

  logic in_accept;
  logic lnew, rnew, ovf, out_free, dup;
  logic [eicd_pkg::DENSE_W-1:0] ld, rd;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign lnew = !lmap_rdata[eicd_pkg::DENSE_W];
  assign rnew = !rmap_rdata[eicd_pkg::DENSE_W];
  assign ovf  = (lnew && (lnext_r >= eicd_pkg::DENSE_LIMIT)) ||
                (rnew && (rnext_r >= eicd_pkg::DENSE_LIMIT));
  assign ld   = lnew ? lnext_r[eicd_pkg::DENSE_W-1:0] : lmap_rdata[eicd_pkg::DENSE_W-1:0];
  assign rd   = rnew ? rnext_r[eicd_pkg::DENSE_W-1:0] : rmap_rdata[eicd_pkg::DENSE_W-1:0];
  assign dup  = !ovf_r && pair_rdata;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    li_nxt        = li_r;
    ri_nxt        = ri_r;
    ld_nxt        = ld_r;
    rd_nxt        = rd_r;
    ovf_nxt       = ovf_r;
    lnext_nxt     = lnext_r;
    rnext_nxt     = rnext_r;
    uniq_nxt      = uniq_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    lmap_we    = 1'b0;
    rmap_we    = 1'b0;
    pair_we    = 1'b0;
    lmap_waddr = li_r;
    rmap_waddr = ri_r;
    lmap_wdata = {1'b1, lnext_r[eicd_pkg::DENSE_W-1:0]};
    rmap_wdata = {1'b1, rnext_r[eicd_pkg::DENSE_W-1:0]};
    pair_waddr = {ld_r, rd_r};
    pair_wdata = 1'b1;
    map_re     = 1'b0;
    pair_re    = 1'b0;
    pair_raddr = {ld, rd};

    unique case (state_r)
      S_CLEAR: begin
        lmap_we    = 1'b1;
        rmap_we    = 1'b1;
        pair_we    = 1'b1;
        lmap_waddr = clr_r[eicd_pkg::RAW_W-1:0];
        rmap_waddr = clr_r[eicd_pkg::RAW_W-1:0];
        pair_waddr = clr_r[eicd_pkg::PAIR_W-1:0];
        lmap_wdata = '0;
        rmap_wdata = '0;
        pair_wdata = 1'b0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == {eicd_pkg::CLR_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          map_re    = 1'b1;
          li_nxt    = in_data.left_raw_id;
          ri_nxt    = in_data.right_raw_id;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        ovf_nxt   = ovf;
        ld_nxt    = ld;
        rd_nxt    = rd;
        state_nxt = S_PAIR;
        if (!ovf) begin
          pair_re = 1'b1;
          lmap_we = lnew;
          rmap_we = rnew;
          if (lnew) begin
            lnext_nxt = lnext_r + 1'b1;
          end
          if (rnew) begin
            rnext_nxt = rnext_r + 1'b1;
          end
        end
      end
      S_PAIR: begin
        if (out_free) begin
          if (!ovf_r && !dup) begin
            pair_we = 1'b1;
            if (uniq_r != eicd_pkg::UNIQUE_MAX) begin
              uniq_nxt = uniq_r + 1'b1;
            end
          end
          out_valid_nxt               = 1'b1;
          out_data_nxt.left_dense_id  = ovf_r ? '0 : ld_r;
          out_data_nxt.right_dense_id = ovf_r ? '0 : rd_r;
          out_data_nxt.is_duplicate   = dup;
          out_data_nxt.overflowed     = ovf_r;
          out_data_nxt.left_total     = lnext_r;
          out_data_nxt.right_total    = rnext_r;
          out_data_nxt.unique_total   = uniq_nxt;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      lnext_r     <= '0;
      rnext_r     <= '0;
      uniq_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      lnext_r     <= lnext_nxt;
      rnext_r     <= rnext_nxt;
      uniq_r      <= uniq_nxt;
      out_valid_r <= out_valid_nxt;
    end
    li_r       <= li_nxt;
    ri_r       <= ri_nxt;
    ld_r       <= ld_nxt;
    rd_r       <= rd_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // left raw id to {valid, dense id}
  eicd_ram #(
    .WIDTH (eicd_pkg::MAP_W),
    .DEPTH (eicd_pkg::RAW_DEPTH)
  ) u_lmap (
    .clk   (clk),
    .we    (lmap_we),
    .waddr (lmap_waddr),
    .wdata (lmap_wdata),
    .re    (map_re),
    .raddr (in_data.left_raw_id),
    .rdata (lmap_rdata)
  );

  // right raw id to {valid, dense id}
  eicd_ram #(
    .WIDTH (eicd_pkg::MAP_W),
    .DEPTH (eicd_pkg::RAW_DEPTH)
  ) u_rmap (
    .clk   (clk),
    .we    (rmap_we),
    .waddr (rmap_waddr),
    .wdata (rmap_wdata),
    .re    (map_re),
    .raddr (in_data.right_raw_id),
    .rdata (rmap_rdata)
  );

  // seen bit per dense pair
  eicd_ram #(
    .WIDTH (1),
    .DEPTH (eicd_pkg::PAIR_DEPTH)
  ) u_pair (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (pair_re),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

endmodule

// File: sv/eicd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eicd_checker
// port level checks of the edge id compaction and dedup unit
// ----------------------------------------------------------------------------
module eicd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input eicd_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // dropped edge reports zero ids and no duplicate
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflowed |->
      out_data.left_dense_id == '0 && out_data.right_dense_id == '0 &&
      !out_data.is_duplicate)
    else $error("overflow result not cleared");

  // totals stay within the dense id range
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.left_total <= eicd_pkg::DENSE_LIMIT &&
                  out_data.right_total <= eicd_pkg::DENSE_LIMIT)
    else $error("total beyond dense id range");

  // an assigned dense id is below its side's total, and the unique total is nonzero
  a_id_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.overflowed |->
      {1'b0, out_data.left_dense_id} < out_data.left_total &&
      {1'b0, out_data.right_dense_id} < out_data.right_total &&
      out_data.unique_total != '0)
    else $error("dense id not below total");

endmodule

bind edge_id_compaction_dedup_unit eicd_checker u_eicd_checker (.*);
